/* rtl/ulsrs_pkg.sv */
package ulsrs_pkg;

  // Driver state code that means the link is up
  localparam logic [2:0] UsbActiveCode = 3'd4;
  localparam logic [7:0] NoFaultCode   = 8'hFF;

  // Register reset values
  localparam logic [15:0] ActivityWinRst = 16'd3000;
  localparam logic [15:0] RecoveryWinRst = 16'd10000;
  localparam logic [15:0] WakeRetryRst   = 16'd250;
  localparam logic [15:0] RestartAftRst  = 16'd2000;
  localparam logic [15:0] GraceRst       = 16'd5000;
  localparam logic [15:0] FrameStallRst  = 16'd100;
  localparam logic [15:0] StuckResetRst  = 16'd10000;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CfgActivityWin = 3'd0,
    CfgRecoveryWin = 3'd1,
    CfgWakeRetry   = 3'd2,
    CfgRestartAft  = 3'd3,
    CfgGrace       = 3'd4,
    CfgFrameStall  = 3'd5,
    CfgStuckReset  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic        func;
    logic [31:0] now_ms;
    logic        owns_usb;
    logic [2:0]  usb_state;
    logic [10:0] frame_number;
    logic        remote_wakeup_enabled;
  } in_item_t;

  typedef struct packed {
    logic        wakeup_request;
    logic        restart_request;
    logic        reboot_request;
    logic        link_dead;
    logic [15:0] state_fault_count;
    logic [15:0] stall_fault_count;
    logic [15:0] self_heal_count;
    logic [15:0] restart_count;
    logic [7:0]  last_fault_state;
  } out_item_t;

  // Zero is the "unset" marker for stamps, so a stamp of zero becomes one
  function automatic logic [31:0] nz(input logic [31:0] t);
    return (t == 32'd0) ? 32'd1 : t;
  endfunction

endpackage

/* rtl/ulsrs_if.sv */
interface ulsrs_in_if;
  logic               valid;
  logic               ready;
  ulsrs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ulsrs_out_if;
  logic                valid;
  logic                ready;
  ulsrs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/usb_link_stall_recovery_sequencer.sv */
// USB link stall recovery sequencer.
// in_i (valid/ready): one item per transfer. func 0 stamps key activity time,
//   func 1 is a housekeeping poll that judges the link and escalates recovery.
// out_o (valid/ready): exactly one result per input item, in order. Pulses
//   (wakeup, restart, reboot) and link_dead, plus the running fault counters.
// cfg_we_i/cfg_idx_i/cfg_data_i: register writes, taken on any clock edge with
//   cfg_we_i high; only write while no item is in flight.
// Path: the item is held in the input register, then its result in the result
//   register. Throughput: one item per cycle unless out_o stalls; the
//   evaluation is a handful of parallel 32-bit subtract/compares between the
//   two registers.
// Reset (rst_ni low, async): all stamps cleared, counters zero, last fault
//   state 0xFF, registers back to their defaults, both stages empty.
// Receiver stall: the result register holds; the input register still takes
//   one more item, after which in_i.ready drops until out_o frees up.
// A reboot request keeps all state; it repeats on every qualifying poll until
//   the link heals or the block is reset.
module usb_link_stall_recovery_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ulsrs_in_if.sink                          in_i,
  ulsrs_out_if.source                       out_o,
  input  logic                              cfg_we_i,
  input  logic [ulsrs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ulsrs_pkg::CfgDataW-1:0]    cfg_data_i
);

  // Config registers
  logic [15:0] act_win_q, rec_win_q, wake_retry_q, restart_aft_q;
  logic [15:0] grace_ms_q, frame_stall_q, stuck_reset_q;

  // Pipeline registers
  logic                 in_vld_q;
  ulsrs_pkg::in_item_t  in_q;
  logic                 out_vld_q, out_vld_d;
  ulsrs_pkg::out_item_t out_q, out_d;
  logic                 adv;

  // Link tracking state
  logic [31:0] last_press_q, last_press_d;
  logic [31:0] stuck_q, stuck_d;
  logic [31:0] last_wake_q, last_wake_d;
  logic [31:0] frame_move_q, frame_move_d;
  logic [31:0] grace_q, grace_d;
  logic [10:0] prev_frame_q, prev_frame_d;
  logic        restart_done_q, restart_done_d;
  logic        seen_healthy_q, seen_healthy_d;
  logic [15:0] state_faults_q, state_faults_d;
  logic [15:0] stall_faults_q, stall_faults_d;
  logic [15:0] self_heals_q, self_heals_d;
  logic [15:0] restarts_q, restarts_d;
  logic [7:0]  fault_code_q, fault_code_d;

  // Handshake: result slot frees when empty or being taken
  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_win_q     <= ulsrs_pkg::ActivityWinRst;
      rec_win_q     <= ulsrs_pkg::RecoveryWinRst;
      wake_retry_q  <= ulsrs_pkg::WakeRetryRst;
      restart_aft_q <= ulsrs_pkg::RestartAftRst;
      grace_ms_q    <= ulsrs_pkg::GraceRst;
      frame_stall_q <= ulsrs_pkg::FrameStallRst;
      stuck_reset_q <= ulsrs_pkg::StuckResetRst;
    end else if (cfg_we_i) begin
      unique case (ulsrs_pkg::cfg_idx_e'(cfg_idx_i))
        ulsrs_pkg::CfgActivityWin: act_win_q     <= cfg_data_i;
        ulsrs_pkg::CfgRecoveryWin: rec_win_q     <= cfg_data_i;
        ulsrs_pkg::CfgWakeRetry:   wake_retry_q  <= cfg_data_i;
        ulsrs_pkg::CfgRestartAft:  restart_aft_q <= cfg_data_i;
        ulsrs_pkg::CfgGrace:       grace_ms_q    <= cfg_data_i;
        ulsrs_pkg::CfgFrameStall:  frame_stall_q <= cfg_data_i;
        ulsrs_pkg::CfgStuckReset:  stuck_reset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  // Evaluation of the registered item
  logic [31:0] now;
  logic        st_bad, frame_chg, stall, dead, in_grace;
  logic [31:0] stuck_eff, stuck_span, idle;
  logic        wake, restart, reboot;

  always_comb begin
    now        = in_q.now_ms;
    st_bad     = in_q.usb_state != ulsrs_pkg::UsbActiveCode;
    frame_chg  = (frame_move_q == 32'd0) || (in_q.frame_number != prev_frame_q);
    stall      = (now - frame_move_q) > {16'd0, frame_stall_q};
    dead       = st_bad || (!frame_chg && stall);
    in_grace   = (grace_q != 32'd0) && ((now - grace_q) < {16'd0, grace_ms_q});
    stuck_eff  = (stuck_q == 32'd0) ? ulsrs_pkg::nz(now) : stuck_q;
    stuck_span = now - stuck_eff;
    idle       = now - last_press_q;

    last_press_d   = last_press_q;
    stuck_d        = stuck_q;
    last_wake_d    = last_wake_q;
    frame_move_d   = frame_move_q;
    grace_d        = grace_q;
    prev_frame_d   = prev_frame_q;
    restart_done_d = restart_done_q;
    seen_healthy_d = seen_healthy_q;
    state_faults_d = state_faults_q;
    stall_faults_d = stall_faults_q;
    self_heals_d   = self_heals_q;
    restarts_d     = restarts_q;
    fault_code_d   = fault_code_q;
    wake           = 1'b0;
    restart        = 1'b0;
    reboot         = 1'b0;

    if (!in_q.func) begin
      last_press_d = now;
    end else if (in_q.owns_usb) begin
      // Judge the link
      if (st_bad) begin
        frame_move_d = 32'd0;
        if (stuck_q == 32'd0) begin
          state_faults_d = state_faults_q + 16'd1;
          fault_code_d   = {5'd0, in_q.usb_state};
        end
      end else if (frame_chg) begin
        prev_frame_d = in_q.frame_number;
        frame_move_d = ulsrs_pkg::nz(now);
      end else if (stall && (stuck_q == 32'd0)) begin
        stall_faults_d = stall_faults_q + 16'd1;
        fault_code_d   = {5'd0, in_q.usb_state};
      end

      if (!dead) begin
        if ((stuck_q != 32'd0) && !restart_done_q) begin
          self_heals_d = self_heals_q + 16'd1;
        end
        seen_healthy_d = 1'b1;
        stuck_d        = 32'd0;
        grace_d        = 32'd0;
        restart_done_d = 1'b0;
      end else if (!in_grace) begin
        grace_d = 32'd0;
        stuck_d = stuck_eff;
        // Recovery only with a key pressed inside the wide window
        if ((last_press_q != 32'd0) && (idle <= {16'd0, rec_win_q})) begin
          if ((idle <= {16'd0, act_win_q}) && !restart_done_q &&
              ((now - last_wake_q) > {16'd0, wake_retry_q})) begin
            last_wake_d = now;
            wake        = in_q.remote_wakeup_enabled;
          end
          if (!restart_done_q && (stuck_span > {16'd0, restart_aft_q})) begin
            restart_done_d = 1'b1;
            grace_d        = ulsrs_pkg::nz(now);
            frame_move_d   = 32'd0;
            restarts_d     = restarts_q + 16'd1;
            restart        = 1'b1;
          end else if (restart_done_q && seen_healthy_q &&
                       (stuck_span > {16'd0, stuck_reset_q})) begin
            reboot = 1'b1;
          end
        end
      end
    end

    out_d.wakeup_request    = wake;
    out_d.restart_request   = restart;
    out_d.reboot_request    = reboot;
    out_d.link_dead         = in_q.func && in_q.owns_usb && dead;
    out_d.state_fault_count = state_faults_d;
    out_d.stall_fault_count = stall_faults_d;
    out_d.self_heal_count   = self_heals_d;
    out_d.restart_count     = restarts_d;
    out_d.last_fault_state  = fault_code_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_press_q   <= 32'd0;
      stuck_q        <= 32'd0;
      last_wake_q    <= 32'd0;
      frame_move_q   <= 32'd0;
      grace_q        <= 32'd0;
      prev_frame_q   <= 11'd0;
      restart_done_q <= 1'b0;
      seen_healthy_q <= 1'b0;
      state_faults_q <= 16'd0;
      stall_faults_q <= 16'd0;
      self_heals_q   <= 16'd0;
      restarts_q     <= 16'd0;
      fault_code_q   <= ulsrs_pkg::NoFaultCode;
    end else if (adv) begin
      last_press_q   <= last_press_d;
      stuck_q        <= stuck_d;
      last_wake_q    <= last_wake_d;
      frame_move_q   <= frame_move_d;
      grace_q        <= grace_d;
      prev_frame_q   <= prev_frame_d;
      restart_done_q <= restart_done_d;
      seen_healthy_q <= seen_healthy_d;
      state_faults_q <= state_faults_d;
      stall_faults_q <= stall_faults_d;
      self_heals_q   <= self_heals_d;
      restarts_q     <= restarts_d;
      fault_code_q   <= fault_code_d;
    end
  end

  // Result register
  always_comb begin
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

`ifndef ASSERT_OFF
  // Any recovery pulse comes only from a poll that found the link dead
  a_pulse_needs_dead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.wakeup_request || out_q.restart_request ||
                  out_q.reboot_request) |-> out_q.link_dead)
    else $error("recovery pulse without dead link");

  // Restart and reboot never in the same result
  a_restart_xor_reboot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.restart_request && out_q.reboot_request))
    else $error("restart and reboot in one result");

  // Restart counter moves only together with a restart pulse
  a_restart_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (restarts_q != $past(restarts_q)) |-> (out_vld_q && out_q.restart_request &&
                                           (out_q.restart_count == restarts_q)))
    else $error("restart counter moved without restart pulse");
`endif

endmodule

/* test/usb_link_stall_recovery_sequencer_test.sv */
module usb_link_stall_recovery_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits and random stimulus shape
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandPerPhase = 236;   // 7 phases, ~1650 random items
  localparam int unsigned NumPhases    = 7;
  localparam int unsigned NumDirected  = 22;
  localparam int unsigned LongHold     = 300;   // receiver hold-off, in cycles

  // Fault code reported for a frame stall (state was active)
  localparam logic [7:0] ActiveFault = {5'd0, ulsrs_pkg::UsbActiveCode};

  // Link behavior the random stimulus is currently emulating
  typedef enum logic [1:0] {
    LinkUp,      // active state, frame counter moving
    LinkDown,    // driver state not active
    LinkFrozen   // active state, frame counter stuck
  } link_mode_e;

  // One directed row: stimulus plus an optional hand-typed result
  typedef struct packed {
    ulsrs_pkg::in_item_t  stim;
    logic                 typed;
    ulsrs_pkg::out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ulsrs_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [ulsrs_pkg::CfgDataW-1:0] cfg_data;

  ulsrs_in_if  in_ch ();
  ulsrs_out_if out_ch ();

  usb_link_stall_recovery_sequencer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the registers and of the link state
  // ---------------------------------------------------------------------------
  logic [15:0] act_win_ms, rec_win_ms, wake_retry_ms, restart_ms;
  logic [15:0] grace_len_ms, frame_stall_lim, reboot_ms;

  logic [31:0] key_stamp, stuck_stamp, wake_stamp, frame_stamp, grace_stamp;
  logic [10:0] seen_frame;
  logic        restarted, was_healthy;
  logic [15:0] n_state_flt, n_stall_flt, n_heal, n_restart;
  logic [7:0]  flt_code;

  // Results still owed by the block, oldest first
  ulsrs_pkg::out_item_t expected_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // Hand-typed result travels with the item, driven like the payload, so the
  // monitor sees the value that belongs to the transfer it is looking at
  logic                 typed_on;
  ulsrs_pkg::out_item_t typed_val;

  // Idle control shared by sender and receiver
  logic steady;     // no gaps and no stalls for a stretch
  logic hold_req;   // ask the receiver for one long hold-off

  // Random stimulus state
  logic [31:0] sim_now;
  logic [10:0] sim_frame;
  int unsigned step_max, key_pct;
  link_mode_e  link_mode;

  dir_row_t dir_tab[NumDirected];

  // Zero marks an unset stamp, so a stamp taken at time zero is stored as one
  function automatic logic [31:0] stamp_of(input logic [31:0] t);
    return (t == 32'd0) ? 32'd1 : t;
  endfunction

  function automatic ulsrs_pkg::out_item_t predict_recovery(input ulsrs_pkg::in_item_t it);
    ulsrs_pkg::out_item_t r;
    logic        dead, in_grace;
    logic [31:0] now, idle, stuck_span;
    r        = '0;
    dead     = 1'b0;
    in_grace = 1'b0;
    now      = it.now_ms;
    if (!it.func) begin
      // key press: only the activity stamp moves
      key_stamp = now;
    end else if (it.owns_usb) begin
      // judge the link
      if (it.usb_state != ulsrs_pkg::UsbActiveCode) begin
        frame_stamp = 32'd0;
        if (stuck_stamp == 32'd0) begin
          n_state_flt = n_state_flt + 16'd1;
          flt_code    = {5'd0, it.usb_state};
        end
        dead = 1'b1;
      end else if (frame_stamp == 32'd0 || it.frame_number != seen_frame) begin
        seen_frame  = it.frame_number;
        frame_stamp = stamp_of(now);
      end else if ((now - frame_stamp) > 32'(frame_stall_lim)) begin
        if (stuck_stamp == 32'd0) begin
          n_stall_flt = n_stall_flt + 16'd1;
          flt_code    = {5'd0, it.usb_state};
        end
        dead = 1'b1;
      end

      if (!dead) begin
        // healed before any restart counts as a self-heal
        if (stuck_stamp != 32'd0 && !restarted) n_heal = n_heal + 16'd1;
        was_healthy = 1'b1;
        stuck_stamp = 32'd0;
        grace_stamp = 32'd0;
        restarted   = 1'b0;
      end else begin
        if (grace_stamp != 32'd0) begin
          if ((now - grace_stamp) < 32'(grace_len_ms)) in_grace = 1'b1;
          else grace_stamp = 32'd0;
        end
        if (!in_grace) begin
          if (stuck_stamp == 32'd0) stuck_stamp = stamp_of(now);
          if (key_stamp != 32'd0) begin
            idle = now - key_stamp;
            if (idle <= 32'(rec_win_ms)) begin
              stuck_span = now - stuck_stamp;
              if (idle <= 32'(act_win_ms) && !restarted &&
                  (now - wake_stamp) > 32'(wake_retry_ms)) begin
                wake_stamp       = now;
                r.wakeup_request = it.remote_wakeup_enabled;
              end
              if (!restarted && stuck_span > 32'(restart_ms)) begin
                restarted         = 1'b1;
                grace_stamp       = stamp_of(now);
                frame_stamp       = 32'd0;
                n_restart         = n_restart + 16'd1;
                r.restart_request = 1'b1;
              end else if (restarted && was_healthy && stuck_span > 32'(reboot_ms)) begin
                r.reboot_request = 1'b1;
              end
            end
          end
        end
      end
    end
    r.link_dead         = dead;
    r.state_fault_count = n_state_flt;
    r.stall_fault_count = n_stall_flt;
    r.self_heal_count   = n_heal;
    r.restart_count     = n_restart;
    r.last_fault_state  = flt_code;
    return r;
  endfunction

  function automatic ulsrs_pkg::in_item_t item(input logic func, input logic [31:0] now,
                                               input logic master, input logic [2:0] st,
                                               input logic [10:0] frame, input logic rwe);
    ulsrs_pkg::in_item_t it;
    it.func                  = func;
    it.now_ms                = now;
    it.owns_usb              = master;
    it.usb_state             = st;
    it.frame_number          = frame;
    it.remote_wakeup_enabled = rwe;
    return it;
  endfunction

  function automatic ulsrs_pkg::out_item_t res(input logic wake, input logic rst,
                                               input logic rbt, input logic dead,
                                               input logic [15:0] sf,
                                               input logic [15:0] stf,
                                               input logic [15:0] sh,
                                               input logic [15:0] rc,
                                               input logic [7:0] code);
    ulsrs_pkg::out_item_t r;
    r.wakeup_request    = wake;
    r.restart_request   = rst;
    r.reboot_request    = rbt;
    r.link_dead         = dead;
    r.state_fault_count = sf;
    r.stall_fault_count = stf;
    r.self_heal_count   = sh;
    r.restart_count     = rc;
    r.last_fault_state  = code;
    return r;
  endfunction

  // Next random item. Mostly well-formed link behavior with slowly moving
  // time, so the block walks through fault, wakeup, restart, grace and reboot;
  // a few items are pure noise over every field.
  function automatic ulsrs_pkg::in_item_t next_stim();
    ulsrs_pkg::in_item_t it;
    logic [2:0]          st;
    it = '0;
    if ($urandom_range(0, 99) < 6) link_mode = link_mode_e'($urandom_range(0, 2));
    sim_now = sim_now + $urandom_range(0, step_max);
    if ($urandom_range(0, 99) < 5) begin
      it.func                  = 1'($urandom_range(0, 1));
      it.now_ms                = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
      it.owns_usb              = 1'($urandom_range(0, 1));
      it.usb_state             = 3'($urandom_range(0, 7));
      it.frame_number          = 11'($urandom_range(0, 2047));
      it.remote_wakeup_enabled = 1'($urandom_range(0, 1));
      return it;
    end
    it.now_ms                = sim_now;
    it.remote_wakeup_enabled = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 99) < key_pct) return it;  // key press
    it.func      = 1'b1;
    it.owns_usb  = ($urandom_range(0, 19) != 0);
    it.usb_state = ulsrs_pkg::UsbActiveCode;
    case (link_mode)
      LinkUp: begin
        if ($urandom_range(0, 4) != 0) sim_frame = sim_frame + 11'($urandom_range(1, 3));
      end
      LinkDown: begin
        // any state but active
        st = 3'($urandom_range(0, 6));
        if (st >= ulsrs_pkg::UsbActiveCode) st = st + 3'd1;
        it.usb_state = st;
      end
      default: ;  // frozen: frame held
    endcase
    it.frame_number = sim_frame;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send(input ulsrs_pkg::in_item_t it, input logic typed,
                      input ulsrs_pkg::out_item_t want);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    typed_on    <= typed;
    typed_val   <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (expected_q.size() == 0);
    @(posedge clk);
  endtask

  // One register write per edge; the predictor's copy follows right away
  // since nothing is in flight
  task automatic set_reg(input ulsrs_pkg::cfg_idx_e idx,
                         input logic [ulsrs_pkg::CfgDataW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      ulsrs_pkg::CfgActivityWin: act_win_ms      = v;
      ulsrs_pkg::CfgRecoveryWin: rec_win_ms      = v;
      ulsrs_pkg::CfgWakeRetry:   wake_retry_ms   = v;
      ulsrs_pkg::CfgRestartAft:  restart_ms      = v;
      ulsrs_pkg::CfgGrace:       grace_len_ms    = v;
      ulsrs_pkg::CfgFrameStall:  frame_stall_lim = v;
      ulsrs_pkg::CfgStuckReset:  reboot_ms       = v;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] act, input logic [15:0] rec,
                         input logic [15:0] wake, input logic [15:0] rst,
                         input logic [15:0] grace, input logic [15:0] stall,
                         input logic [15:0] rbt);
    set_reg(ulsrs_pkg::CfgActivityWin, act);
    set_reg(ulsrs_pkg::CfgRecoveryWin, rec);
    set_reg(ulsrs_pkg::CfgWakeRetry,   wake);
    set_reg(ulsrs_pkg::CfgRestartAft,  rst);
    set_reg(ulsrs_pkg::CfgGrace,       grace);
    set_reg(ulsrs_pkg::CfgFrameStall,  stall);
    set_reg(ulsrs_pkg::CfgStuckReset,  rbt);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i, p;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    cfg_we      = 1'b0;
    cfg_idx     = ulsrs_pkg::CfgActivityWin;
    cfg_data    = '0;
    typed_on    = 1'b0;
    typed_val   = '0;
    steady      = 1'b0;
    hold_req    = 1'b0;
    sim_now     = 32'd1;
    sim_frame   = 11'd0;
    step_max    = 300;
    key_pct     = 10;
    link_mode   = LinkUp;

    // predictor at its reset state
    act_win_ms      = ulsrs_pkg::ActivityWinRst;
    rec_win_ms      = ulsrs_pkg::RecoveryWinRst;
    wake_retry_ms   = ulsrs_pkg::WakeRetryRst;
    restart_ms      = ulsrs_pkg::RestartAftRst;
    grace_len_ms    = ulsrs_pkg::GraceRst;
    frame_stall_lim = ulsrs_pkg::FrameStallRst;
    reboot_ms       = ulsrs_pkg::StuckResetRst;
    key_stamp   = '0; stuck_stamp = '0; wake_stamp  = '0;
    frame_stamp = '0; grace_stamp = '0; seen_frame  = '0;
    restarted   = 1'b0; was_healthy = 1'b0;
    n_state_flt = '0; n_stall_flt = '0; n_heal = '0; n_restart = '0;
    flt_code    = ulsrs_pkg::NoFaultCode;

    // Directed walk at reset register values. Typed results follow one dead
    // spell through wakeup, restart, grace and reboot; the rows around the
    // 32-bit time wrap are left to the predictor.
    dir_tab[0]  = '{item(1, 32'd1000, 0, 3'd0, 11'd0, 1), 1'b1,       // not master
                    res(0, 0, 0, 0, 0, 0, 0, 0, ulsrs_pkg::NoFaultCode)};
    dir_tab[1]  = '{item(0, 32'd0, 0, 3'd0, 11'd0, 0), 1'b1,          // press at zero
                    res(0, 0, 0, 0, 0, 0, 0, 0, ulsrs_pkg::NoFaultCode)};
    dir_tab[2]  = '{item(1, 32'd0, 1, ulsrs_pkg::UsbActiveCode, 11'd0, 0), 1'b1, // stamp at 0
                    res(0, 0, 0, 0, 0, 0, 0, 0, ulsrs_pkg::NoFaultCode)};
    dir_tab[3]  = '{item(1, 32'd2, 1, ulsrs_pkg::UsbActiveCode, 11'd0, 0), 1'b1,
                    res(0, 0, 0, 0, 0, 0, 0, 0, ulsrs_pkg::NoFaultCode)};
    dir_tab[4]  = '{item(1, 32'd200, 1, ulsrs_pkg::UsbActiveCode, 11'd0, 0), 1'b1, // stall
                    res(0, 0, 0, 1, 0, 1, 0, 0, ActiveFault)};
    dir_tab[5]  = '{item(1, 32'd300, 1, 3'd7, 11'd2047, 1), 1'b1,     // never pressed
                    res(0, 0, 0, 1, 0, 1, 0, 0, ActiveFault)};
    dir_tab[6]  = '{item(0, 32'd400, 1, 3'd7, 11'd2047, 1), 1'b1,
                    res(0, 0, 0, 0, 0, 1, 0, 0, ActiveFault)};
    dir_tab[7]  = '{item(1, 32'd500, 1, 3'd0, 11'd5, 1), 1'b1,        // wakeup
                    res(1, 0, 0, 1, 0, 1, 0, 0, ActiveFault)};
    dir_tab[8]  = '{item(1, 32'd600, 1, 3'd0, 11'd5, 1), 1'b1,        // throttled
                    res(0, 0, 0, 1, 0, 1, 0, 0, ActiveFault)};
    dir_tab[9]  = '{item(1, 32'd2201, 1, 3'd3, 11'd5, 1), 1'b1,       // wakeup and restart
                    res(1, 1, 0, 1, 0, 1, 0, 1, ActiveFault)};
    dir_tab[10] = '{item(1, 32'd3000, 1, 3'd3, 11'd5, 1), 1'b1,       // in grace
                    res(0, 0, 0, 1, 0, 1, 0, 1, ActiveFault)};
    dir_tab[11] = '{item(1, 32'd7201, 1, 3'd3, 11'd5, 1), 1'b1,       // grace just over
                    res(0, 0, 0, 1, 0, 1, 0, 1, ActiveFault)};
    dir_tab[12] = '{item(0, 32'd10000, 0, 3'd0, 11'd0, 0), 1'b1,
                    res(0, 0, 0, 0, 0, 1, 0, 1, ActiveFault)};
    dir_tab[13] = '{item(1, 32'd10201, 1, 3'd1, 11'd5, 1), 1'b1,      // reboot
                    res(0, 0, 1, 1, 0, 1, 0, 1, ActiveFault)};
    dir_tab[14] = '{item(1, 32'd10300, 1, ulsrs_pkg::UsbActiveCode, 11'd9, 1), 1'b1, // healed
                    res(0, 0, 0, 0, 0, 1, 0, 1, ActiveFault)};
    dir_tab[15] = '{item(1, 32'd10350, 1, 3'd2, 11'd9, 0), 1'b1,      // state fault, no permission
                    res(0, 0, 0, 1, 1, 1, 0, 1, 8'd2)};
    dir_tab[16] = '{item(1, 32'd10400, 1, ulsrs_pkg::UsbActiveCode, 11'd10, 0), 1'b1, // self-heal
                    res(0, 0, 0, 0, 1, 1, 1, 1, 8'd2)};
    dir_tab[17] = '{item(1, 32'hFFFF_FFF0, 1, ulsrs_pkg::UsbActiveCode, 11'd10, 1), 1'b0, '0};
    dir_tab[18] = '{item(0, 32'hFFFF_FFFF, 0, 3'd0, 11'd0, 0), 1'b0, '0};
    dir_tab[19] = '{item(1, 32'd0, 1, 3'd5, 11'd10, 1), 1'b0, '0};    // time wraps to zero
    dir_tab[20] = '{item(1, 32'h0000_0100, 1, 3'd6, 11'd10, 1), 1'b0, '0};
    dir_tab[21] = '{item(1, 32'h0000_0200, 0, 3'd6, 11'd10, 1), 1'b1,
                    res(0, 0, 0, 0, 1, 2, 1, 1, ActiveFault)};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < NumDirected; i++) send(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
    drain();

    // Random phases, each under its own register setting; writes only once
    // the block has handed back everything
    sim_now = 32'd20000;
    for (p = 0; p < NumPhases; p++) begin
      case (p)
        0: step_max = 300;                                   // reset values
        1: begin
          cfg_all(16'd40, 16'd160, 16'd8, 16'd30, 16'd50, 16'd6, 16'd120);
          step_max = 12;
        end
        2: begin
          cfg_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
          step_max = 2;
        end
        3: begin
          cfg_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          step_max = 5000;
        end
        4: begin
          cfg_all(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                  16'($urandom_range(0, 300)));
          step_max = 25;
        end
        5: begin
          // back to reset values, with time running across the 32-bit wrap
          cfg_all(ulsrs_pkg::ActivityWinRst, ulsrs_pkg::RecoveryWinRst,
                  ulsrs_pkg::WakeRetryRst, ulsrs_pkg::RestartAftRst,
                  ulsrs_pkg::GraceRst, ulsrs_pkg::FrameStallRst,
                  ulsrs_pkg::StuckResetRst);
          step_max = 400;
          sim_now  = 32'hFFFF_4000;
        end
        default: begin
          cfg_all(16'hFFFF, 16'hFFFF, 16'd0, 16'd20, 16'd0, 16'd0, 16'd300);
          step_max = 40;
        end
      endcase
      for (i = 0; i < RandPerPhase; i++) begin
        if (i % 40 == 0) begin
          case ($urandom_range(0, 3))
            0:       key_pct = 0;
            1:       key_pct = 4;
            2:       key_pct = 12;
            default: key_pct = 30;
          endcase
          steady = ($urandom_range(0, 3) == 0);
        end
        // receiver goes quiet for a long stretch while we keep offering
        if (p == 1 && i == 100) hold_req = 1'b1;
        // sender pauses until the pipeline is empty
        if (p == 3 && i == 120) drain();
        send(next_stim(), 1'b0, '0);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result, one long hold on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LongHold;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: predict on each input transfer, compare on each output transfer
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ulsrs_pkg::out_item_t want, got, pred;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
        end else begin
          want = expected_q.pop_front();
          check_field("wakeup_request", 32'(want.wakeup_request),
                      32'(got.wakeup_request));
          check_field("restart_request", 32'(want.restart_request),
                      32'(got.restart_request));
          check_field("reboot_request", 32'(want.reboot_request),
                      32'(got.reboot_request));
          check_field("link_dead", 32'(want.link_dead), 32'(got.link_dead));
          check_field("state_fault_count", 32'(want.state_fault_count),
                      32'(got.state_fault_count));
          check_field("stall_fault_count", 32'(want.stall_fault_count),
                      32'(got.stall_fault_count));
          check_field("self_heal_count", 32'(want.self_heal_count),
                      32'(got.self_heal_count));
          check_field("restart_count", 32'(want.restart_count),
                      32'(got.restart_count));
          check_field("last_fault_state", 32'(want.last_fault_state),
                      32'(got.last_fault_state));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        // predictor always advances; a typed row overrides what is expected
        pred = predict_recovery(in_ch.data);
        expected_q.push_back(typed_on ? typed_val : pred);
      end
    end
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/ulsrs_pkg.sv
rtl/ulsrs_if.sv
rtl/usb_link_stall_recovery_sequencer.sv
test/usb_link_stall_recovery_sequencer_test.sv
